[hw/rtl/tps_pkg.sv]
// Package for the timed pattern sequencer: stream layout constants, display types
// and the decimal digit split. No dependencies.
`default_nettype none
package tps_pkg;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned SEL_W      = 4;
  localparam int unsigned WR_PAT_W   = 4;
  localparam int unsigned WR_STEP_W  = 6;
  localparam int unsigned WR_DUR_W   = 16;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned SHOWN_W    = 8;

  localparam logic [SEL_W-1:0] MAX_SEL_RESET = 4'd12;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef struct packed {
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
  } digits_t;

  // Split a small value into decimal digits, tens saturated at nine
  function automatic digits_t to_digits(input logic [SHOWN_W-1:0] val);
    digits_t                    d;
    logic [SHOWN_W+7:0]         recip;
    logic [SHOWN_W-1:0]         q;
    logic [SHOWN_W+DIGIT_W-1:0] prod;
    // divide by ten through a reciprocal multiply, exact for eight-bit values
    recip  = (SHOWN_W+8)'(val) * (SHOWN_W+8)'(205);
    q      = SHOWN_W'(recip >> 11);
    prod   = (SHOWN_W+DIGIT_W)'(q) * (SHOWN_W+DIGIT_W)'(10);
    d.tens = (q > SHOWN_W'(9)) ? DIGIT_W'(9) : DIGIT_W'(q);
    d.ones = DIGIT_W'(val - prod[SHOWN_W-1:0]);
    return d;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/tps_dur_mem.sv]
// Duration table: synchronous memory, one write port and two registered read ports.
// Depends on nothing.
`default_nettype none
module tps_dur_mem #(
  parameter int unsigned DEPTH = 768,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr_a,
  input  wire logic [AW-1:0]    rd_addr_b,
  output logic      [WIDTH-1:0] rd_data_a,
  output logic      [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/timed_pattern_sequencer_unit.sv]
// Timed pattern sequencer top level: buttons, run control, playback and display.
// Depends on tps_pkg and tps_dur_mem.
//
//   channel  | ports                      | payload
//   input    | in_tvalid/in_tready        | in_tuser: action; in_tdata: see port
//   result   | out_tvalid/out_tready      | out_tdata: see port
//   config   | cfg_wr_en/cfg_wr_data      | max_selection
//
// One item at a time: the accept cycle issues both table reads (current and
// next step) on the memory's two read ports, the playback stage after it plays back.
// The result register takes the outcome; a new item is accepted while it waits.
// Reset is synchronous; the table is not cleared. A stalled result holds the
// playback stage until out_tready.
`default_nettype none
module timed_pattern_sequencer_unit
  import tps_pkg::*;
#(
  parameter int unsigned PATTERNS      = 12,
  parameter int unsigned STEPS         = 64,
  parameter int unsigned DURATION_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [0] button_up [1] button_down [2] run_input [6:3] write_pattern
  // [12:7] write_step [28:13] write_duration, rest zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [0] action
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] drive_level [4:1] digit_tens [8:5] digit_ones [9] running [10] paused
  // [11] finished, rest zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_wr_en,
  input  wire logic [SEL_W-1:0]      cfg_wr_data
);

  localparam int unsigned DEPTH  = PATTERNS * STEPS;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned STEP_W = $clog2(STEPS + 1);
  localparam int unsigned LIM_W  = SEL_W + 1;

  logic                     in_acc;
  logic                     s1_done;
  logic                     is_write;
  logic                     b_up, b_down, run_in;
  logic [WR_PAT_W-1:0]      wr_pat;
  logic [WR_STEP_W-1:0]     wr_step;
  logic [WR_DUR_W-1:0]      wr_dur;

  logic [SEL_W-1:0]         max_sel_r;
  logic [SEL_W-1:0]         sel_r, sel_nxt;
  logic                     up_latch_r, up_latch_nxt;
  logic                     down_latch_r, down_latch_nxt;
  logic                     run_r, run_nxt;
  logic                     pause_r, pause_nxt;
  logic                     end_r, end_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [DURATION_BITS-1:0] tick_r, tick_nxt;
  logic                     level_r, level_nxt;
  digits_t                  disp_r, disp_nxt;
  logic                     s1_valid_r;
  logic                     s1_tick_r;
  logic                     cur_ok_r, nxt_ok_r;
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r, out_data_nxt;

  logic [LIM_W-1:0]         limit;
  logic [SHOWN_W-1:0]       shown;
  logic [STEP_W:0]          step_p1;
  logic [AW-1:0]            rd_addr_a, rd_addr_b, wr_addr;
  logic                     wr_ok;
  logic [DURATION_BITS-1:0] rd_a, rd_b, e0, e1, tick_inc;

  assign is_write = (in_tuser == ACT_WRITE);
  assign b_up     = in_tdata[0];
  assign b_down   = in_tdata[1];
  assign run_in   = in_tdata[2];
  assign wr_pat   = in_tdata[6:3];
  assign wr_step  = in_tdata[12:7];
  assign wr_dur   = in_tdata[28:13];

  assign in_tready = !s1_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign s1_done   = s1_valid_r && (!out_valid_r || out_tready);

  // buttons, display snapshot and run control at accept
  always_comb begin
    limit          = (LIM_W'(max_sel_r) < LIM_W'(PATTERNS)) ? LIM_W'(max_sel_r)
                                                            : LIM_W'(PATTERNS);
    sel_nxt        = sel_r;
    up_latch_nxt   = up_latch_r;
    down_latch_nxt = down_latch_r;
    if (!b_up && !up_latch_r) begin
      up_latch_nxt = 1'b1;
      if (LIM_W'(sel_r) < limit) sel_nxt = sel_r + SEL_W'(1);
    end else if (b_up && up_latch_r) begin
      up_latch_nxt = 1'b0;
    end
    if (!b_down && !down_latch_r) begin
      down_latch_nxt = 1'b1;
      if (sel_nxt > SEL_W'(1)) sel_nxt = sel_nxt - SEL_W'(1);
    end else if (b_down && down_latch_r) begin
      down_latch_nxt = 1'b0;
    end
    if (run_r) shown = SHOWN_W'(step_r >> 1);
    else       shown = SHOWN_W'(sel_nxt);
    disp_nxt  = to_digits(shown);
    run_nxt   = run_r;
    pause_nxt = pause_r;
    priority if (!run_in) begin
      run_nxt   = 1'b1;
      pause_nxt = 1'b0;
    end else if (!end_r) begin
      pause_nxt = 1'b1;
    end else begin
      run_nxt = 1'b0;
    end
  end

  assign step_p1   = {1'b0, step_r} + (STEP_W+1)'(1);
  assign rd_addr_a = AW'((int'(sel_nxt) - 1) * STEPS
                         + ((step_r < STEP_W'(STEPS)) ? int'(step_r) : 0));
  assign rd_addr_b = AW'((int'(sel_nxt) - 1) * STEPS
                         + ((step_p1 < (STEP_W+1)'(STEPS)) ? int'(step_p1) : 0));
  assign wr_ok     = (int'(wr_pat) < PATTERNS) && (int'(wr_step) < STEPS);
  assign wr_addr   = AW'(int'(wr_pat) * STEPS + int'(wr_step));

  tps_dur_mem #(
    .DEPTH (DEPTH),
    .WIDTH (DURATION_BITS),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (in_acc && is_write && wr_ok),
    .wr_addr   (wr_addr),
    .wr_data   (DURATION_BITS'(wr_dur)),
    .rd_en     (in_acc && !is_write),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // playback in the stage after accept
  always_comb begin
    e0        = cur_ok_r ? rd_a : '0;
    e1        = nxt_ok_r ? rd_b : '0;
    tick_inc  = (tick_r != '1) ? tick_r + DURATION_BITS'(1) : tick_r;
    step_nxt  = step_r;
    tick_nxt  = tick_r;
    level_nxt = level_r;
    end_nxt   = end_r;
    if (s1_tick_r) begin
      if (run_r) begin
        if (!pause_r) begin
          if (e0 == '0) begin
            level_nxt = 1'b0;
            end_nxt   = 1'b1;
          end else if (tick_inc >= e0) begin
            level_nxt = !step_r[0];
            step_nxt  = step_r + STEP_W'(1);
            tick_nxt  = '0;
            end_nxt   = (e1 == '0);
            if (e1 == '0) level_nxt = 1'b0;
          end else begin
            tick_nxt = tick_inc;
          end
        end
      end else begin
        step_nxt  = '0;
        tick_nxt  = '0;
        level_nxt = 1'b0;
      end
    end
    out_data_nxt = OUT_DATA_W'({end_nxt, pause_r, run_r, disp_r.ones, disp_r.tens,
                                level_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_sel_r    <= MAX_SEL_RESET;
      sel_r        <= SEL_W'(1);
      up_latch_r   <= 1'b0;
      down_latch_r <= 1'b0;
      run_r        <= 1'b0;
      pause_r      <= 1'b0;
      end_r        <= 1'b0;
      step_r       <= '0;
      tick_r       <= '0;
      level_r      <= 1'b0;
      disp_r       <= '{tens: '0, ones: DIGIT_W'(1)};
      s1_valid_r   <= 1'b0;
      s1_tick_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) max_sel_r <= cfg_wr_data;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        s1_tick_r  <= !is_write;
        if (!is_write) begin
          sel_r        <= sel_nxt;
          up_latch_r   <= up_latch_nxt;
          down_latch_r <= down_latch_nxt;
          disp_r       <= disp_nxt;
          run_r        <= run_nxt;
          pause_r      <= pause_nxt;
        end
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
        step_r     <= step_nxt;
        tick_r     <= tick_nxt;
        level_r    <= level_nxt;
        end_r      <= end_nxt;
      end
      if (s1_done)         out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_ok_r <= (step_r < STEP_W'(STEPS));
      nxt_ok_r <= (step_p1 < (STEP_W+1)'(STEPS));
    end
    if (s1_done) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_end_low: assert property (@(posedge clk) disable iff (!rst_n)
    end_r |-> !level_r) else $error("level high with pattern ended");
  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r != '0) else $error("selection at zero");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_W'(STEPS)) else $error("step beyond table");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_acc) else $error("transfer accepted while busy");

endmodule
`default_nettype wire
